>>> rtl/core/battery_energy_mode_fsm_defines.svh
`ifndef BATTERY_ENERGY_MODE_FSM_DEFINES_SVH
`define BATTERY_ENERGY_MODE_FSM_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during rst
`define BEMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off during rst
`define BEMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bemf_pkg.sv
package bemf_pkg;

  typedef enum logic [2:0] {
    MODE_STARTUP  = 3'd0,
    MODE_NORMAL   = 3'd1,
    MODE_LOW      = 3'd2,
    MODE_CRITICAL = 3'd3,
    MODE_SHUTDOWN = 3'd4
  } mode_t;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SHUTDOWN_MV      = 2'd0;
  localparam reg_idx_t REG_CRITICAL_WAKE_MV = 2'd1;
  localparam reg_idx_t REG_OVERCHARGE_MV    = 2'd2;
  localparam reg_idx_t REG_SOLAR_WAKE_MW    = 2'd3;

  localparam logic [15:0] SHUTDOWN_MV_RST      = 16'd11000;
  localparam logic [15:0] CRITICAL_WAKE_MV_RST = 16'd11500;
  localparam logic [15:0] OVERCHARGE_MV_RST    = 16'd14400;
  localparam logic [19:0] SOLAR_WAKE_MW_RST    = 20'd1000;

  localparam logic [7:0] STARTUP_TICKS  = 8'd20;
  localparam logic [6:0] NORMAL_ENTRY   = 7'd30;
  localparam logic [6:0] CRITICAL_ENTRY = 7'd10;
  localparam logic [6:0] NORMAL_RETURN  = 7'd40;
  localparam logic [6:0] LOW_RETURN     = 7'd20;

  localparam int unsigned GREEN_BLINK_BIT = 2;
  localparam int unsigned RED_BLINK_BIT   = 3;

endpackage

>>> rtl/core/bemf_ifs.sv
interface bemf_tick_if;
  logic        valid;
  logic        ready;
  logic [6:0]  charge_percent;
  logic [15:0] battery_mv;
  logic [19:0] solar_mw;

  modport source (output valid, charge_percent, battery_mv, solar_mw, input ready);
  modport sink   (input valid, charge_percent, battery_mv, solar_mw, output ready);
endinterface

interface bemf_result_if;
  logic       valid;
  logic       ready;
  logic       load_lighting;
  logic       load_middle;
  logic       load_radio_tv;
  logic       lamp_green;
  logic       lamp_orange;
  logic       led_red;
  logic [2:0] mode_code;

  modport source (
    output valid, load_lighting, load_middle, load_radio_tv,
           lamp_green, lamp_orange, led_red, mode_code,
    input  ready
  );
  modport sink (
    input  valid, load_lighting, load_middle, load_radio_tv,
           lamp_green, lamp_orange, led_red, mode_code,
    output ready
  );
endinterface

>>> rtl/core/battery_energy_mode_fsm.sv
// Channel   Dir  Request contents
// -------   ---  ------------------------------------------------------------
// tick      in   charge_percent, battery_mv, solar_mw
// result    out  three load enables, three LED drives, mode_code
// apb       in   threshold register writes and reads (four registers)
//
// One request per clock: the mode update and the result are one level of
// compares between the input handshake and the result register.
// tick is taken whenever the result register is empty or being drained,
// so a stalled result only holds tick off for as long as it is not taken.
// rst (synchronous) returns startup mode, a zero counter, empty output and
// the default thresholds.
`include "battery_energy_mode_fsm_defines.svh"

module battery_energy_mode_fsm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bemf_pkg::AddrWidth-1:0] paddr,
  input  logic [bemf_pkg::DataWidth-1:0] pwdata,
  output logic [bemf_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  bemf_tick_if.sink                     tick,
  bemf_result_if.source                 result
);
  import bemf_pkg::*;

  logic [15:0] shutdown_mv;
  logic [15:0] critical_wake_mv;
  logic [15:0] overcharge_mv;
  logic [19:0] solar_wake_mw;

  mode_t       mode;
  mode_t       mode_next;
  logic [7:0]  tick_count;
  logic [7:0]  cnt_inc;

  logic        out_valid;
  logic        take;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  logic        l0, l1, l2, g, o, r;
  logic        res_l0, res_l1, res_l2, res_g, res_o, res_r;
  mode_t       res_mode;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_SHUTDOWN_MV:      prdata = {16'd0, shutdown_mv};
      REG_CRITICAL_WAKE_MV: prdata = {16'd0, critical_wake_mv};
      REG_OVERCHARGE_MV:    prdata = {16'd0, overcharge_mv};
      REG_SOLAR_WAKE_MW:    prdata = {12'd0, solar_wake_mw};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shutdown_mv      <= SHUTDOWN_MV_RST;
      critical_wake_mv <= CRITICAL_WAKE_MV_RST;
      overcharge_mv    <= OVERCHARGE_MV_RST;
      solar_wake_mw    <= SOLAR_WAKE_MW_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SHUTDOWN_MV:      shutdown_mv      <= pwdata[15:0];
        REG_CRITICAL_WAKE_MV: critical_wake_mv <= pwdata[15:0];
        REG_OVERCHARGE_MV:    overcharge_mv    <= pwdata[15:0];
        REG_SOLAR_WAKE_MW:    solar_wake_mw    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  assign tick.ready = !out_valid || result.ready;
  assign take       = tick.valid && tick.ready;
  assign cnt_inc    = tick_count + 8'd1;

  // Load and lamp outputs follow the mode in force before the transition
  always_comb begin
    l0 = 1'b0; l1 = 1'b0; l2 = 1'b0;
    g  = 1'b0; o  = 1'b0; r  = 1'b0;
    mode_next = mode;
    case (mode)
      MODE_STARTUP: begin
        g = cnt_inc[GREEN_BLINK_BIT];
        if (cnt_inc > STARTUP_TICKS) begin
          if (tick.battery_mv > shutdown_mv) begin
            mode_next = (tick.charge_percent > NORMAL_ENTRY) ? MODE_NORMAL : MODE_LOW;
          end else begin
            mode_next = MODE_SHUTDOWN;
          end
        end
      end
      MODE_NORMAL: begin
        l0 = 1'b1; l1 = 1'b1; l2 = 1'b1; g = 1'b1;
        o  = tick.battery_mv > overcharge_mv;
        if (tick.charge_percent < CRITICAL_ENTRY) begin
          mode_next = MODE_CRITICAL;
        end else if (tick.charge_percent < NORMAL_ENTRY) begin
          mode_next = MODE_LOW;
        end
      end
      MODE_LOW: begin
        l0 = 1'b1; l1 = 1'b1; o = 1'b1;
        if (tick.charge_percent < CRITICAL_ENTRY) begin
          mode_next = MODE_CRITICAL;
        end else if (tick.charge_percent > NORMAL_RETURN) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_CRITICAL: begin
        l0 = 1'b1; r = 1'b1;
        // low-voltage shutdown wins over charge recovery
        if (tick.battery_mv < shutdown_mv) begin
          mode_next = MODE_SHUTDOWN;
        end else if (tick.charge_percent > LOW_RETURN) begin
          mode_next = MODE_LOW;
        end
      end
      MODE_SHUTDOWN: begin
        r = cnt_inc[RED_BLINK_BIT];
        if (tick.solar_mw > solar_wake_mw && tick.battery_mv > critical_wake_mv) begin
          mode_next = MODE_CRITICAL;
        end
      end
      default: mode_next = MODE_STARTUP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_STARTUP;
      tick_count <= 8'd0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        mode       <= mode_next;
        tick_count <= (mode_next != mode) ? 8'd0 : cnt_inc;
        out_valid  <= 1'b1;
      end else if (result.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_l0   <= l0;
      res_l1   <= l1;
      res_l2   <= l2;
      res_g    <= g;
      res_o    <= o;
      res_r    <= r;
      res_mode <= mode_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.load_lighting = res_l0;
  assign result.load_middle   = res_l1;
  assign result.load_radio_tv = res_l2;
  assign result.lamp_green    = res_g;
  assign result.lamp_orange   = res_o;
  assign result.led_red       = res_r;
  assign result.mode_code     = res_mode;

  `BEMF_ASSERT_NEXT(a_change_clears_count, take && (mode_next != mode), tick_count == 8'd0, "mode change did not clear the tick counter")
  `BEMF_ASSERT_NOW(a_result_tracks_mode, out_valid, result.mode_code == mode, "pending result mode differs from mode register")
  `BEMF_ASSERT_NEXT(a_idle_state_holds, !take, $stable(mode) && $stable(tick_count), "state moved without an accepted tick")
  `BEMF_ASSERT_NOW(a_startup_bounded, mode == MODE_STARTUP, tick_count <= STARTUP_TICKS, "startup counter ran past its limit")

endmodule
